FILE: design/srm_pkg.sv
package srm_pkg;

	localparam int TW   = 32;
	localparam int CNTW = 64;
	localparam int RW   = 64;
	localparam int IW   = 16;
	localparam int PW   = CNTW + IW;
	localparam int DW   = 49;

	localparam logic [IW-1:0] INTERVAL_RST = 16'd1000;
	localparam logic [16:0]   RATE_DIV     = 17'd125000;

	typedef logic [IW-1:0] interval_t;
	typedef logic [DW-1:0] div_t;

	typedef struct packed {
		logic [TW-1:0]   now_ms;
		logic [CNTW-1:0] counter_total;
	} in_word_t;

	typedef struct packed {
		logic [RW-1:0] rate_estimate;
		logic          fresh;
	} out_word_t;

endpackage

FILE: design/srm_chan_if.sv
interface srm_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: design/smoothed_rate_meter.sv
// First and too-soon items go from ST_IDLE straight to ST_FIN and then to the
// registered result; updating items first pass ST_MUL (shift-add multiply by the
// interval), ST_DIV (bit-serial restoring divide) and ST_SUM.
// One word in flight: ST_FIN waits until the result slot is free, and
// a new word is taken while the previous result waits.
// arst_n clears the history, the held estimate and sets interval to 1000.
module smoothed_rate_meter #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	srm_chan_if.sink    item,
	srm_chan_if.source  result,
	srm_chan_if.sink    cfg
);

	localparam int NB = srm_pkg::PW + FRAC_BITS;
	localparam int CW = $clog2(NB);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SUM,
		ST_FIN
	} state_t;

	state_t state_q;

	logic                       started_q;
	logic [srm_pkg::TW-1:0]     last_time_q;
	logic [srm_pkg::CNTW-1:0]   last_count_q;
	logic [srm_pkg::RW-1:0]     last_rate_q;
	srm_pkg::interval_t         interval_q;

	logic [srm_pkg::TW-1:0]     dtime_q;
	logic [srm_pkg::CNTW-1:0]   dcount_q;
	srm_pkg::interval_t         ibits_q;
	logic [srm_pkg::PW-1:0]     prod_q;
	srm_pkg::div_t              d_q;
	srm_pkg::div_t              rem_q;
	logic [srm_pkg::RW:0]       quo_q;
	logic                       ovf_q;
	logic [CW-1:0]              cnt_q;

	srm_pkg::out_word_t         res_q;
	srm_pkg::out_word_t         out_q;
	logic                       out_valid_q;

	logic [srm_pkg::TW-1:0]     dtime;
	logic [srm_pkg::DW:0]       trial;
	logic [srm_pkg::DW:0]       dext;
	logic                       ge;
	srm_pkg::div_t              rem_next;
	logic [srm_pkg::RW:0]       raw;
	logic                       sat;
	logic [srm_pkg::RW+1:0]     sum;
	logic [srm_pkg::RW-1:0]     new_rate;
	logic                       out_free;

	assign item.ready   = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;
	assign out_free     = !out_valid_q || result.ready;

	assign dtime    = item.data.now_ms - last_time_q;
	assign trial    = {rem_q, prod_q[srm_pkg::PW-1]};
	assign dext     = {1'b0, d_q};
	assign ge       = trial >= dext;
	assign rem_next = ge ? srm_pkg::div_t'(trial - dext) : trial[srm_pkg::DW-1:0];

	always_comb begin
		if (d_q == '0) begin
			raw = '0;
			sat = 1'b0;
		end else begin
			raw = quo_q;
			sat = ovf_q;
		end
		sum = {1'b0, raw} + {2'b0, last_rate_q};
		new_rate = (sat || sum[srm_pkg::RW+1]) ? '1 : sum[srm_pkg::RW:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			started_q    <= 1'b0;
			last_time_q  <= '0;
			last_count_q <= '0;
			last_rate_q  <= '0;
			interval_q   <= srm_pkg::INTERVAL_RST;
			dtime_q      <= '0;
			dcount_q     <= '0;
			ibits_q      <= '0;
			prod_q       <= '0;
			d_q          <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
			ovf_q        <= 1'b0;
			cnt_q        <= '0;
			res_q        <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid)
				interval_q <= cfg.data;
			if (out_valid_q && result.ready && state_q != ST_FIN)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						if (!started_q) begin
							started_q    <= 1'b1;
							last_time_q  <= item.data.now_ms;
							last_count_q <= item.data.counter_total;
							res_q        <= '0;
							state_q      <= ST_FIN;
						end else if ({16'b0, dtime} < {32'b0, interval_q}) begin
							res_q.rate_estimate <= last_rate_q;
							res_q.fresh         <= 1'b0;
							state_q             <= ST_FIN;
						end else begin
							last_time_q  <= item.data.now_ms;
							last_count_q <= item.data.counter_total;
							dtime_q      <= dtime;
							dcount_q     <= item.data.counter_total - last_count_q;
							ibits_q      <= interval_q;
							prod_q       <= '0;
							cnt_q        <= '0;
							state_q      <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					d_q     <= srm_pkg::div_t'(dtime_q) * srm_pkg::div_t'(srm_pkg::RATE_DIV);
					prod_q  <= {prod_q[srm_pkg::PW-2:0], 1'b0}
						+ (ibits_q[srm_pkg::IW-1] ? {16'b0, dcount_q} : '0);
					ibits_q <= {ibits_q[srm_pkg::IW-2:0], 1'b0};
					if (cnt_q == CW'(srm_pkg::IW - 1)) begin
						cnt_q   <= '0;
						rem_q   <= '0;
						quo_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					rem_q  <= rem_next;
					prod_q <= {prod_q[srm_pkg::PW-2:0], 1'b0};
					quo_q  <= {quo_q[srm_pkg::RW-1:0], ge};
					ovf_q  <= ovf_q | quo_q[srm_pkg::RW];
					if (cnt_q == CW'(NB - 1))
						state_q <= ST_SUM;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_SUM: begin
					last_rate_q         <= new_rate;
					res_q.rate_estimate <= new_rate;
					res_q.fresh         <= 1'b1;
					state_q             <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
